/* rtl/soch_pkg.sv */
// ---------------------------------------------------------------------------
// soch_pkg: shared types and constants for the socket owner hash cache
// Field widths, operation codes and the work item passed from the front
// end to the probe engine.
// ---------------------------------------------------------------------------
`default_nettype none

package soch_pkg;

  localparam int KIND_W = 2;
  localparam int KEY_W  = 64;
  localparam int VAL_W  = 22;
  localparam int HASH_W = 8;
  localparam int HASH_N = 1 << HASH_W;

  // Input operation codes
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  // Operation class after decode (zero-key lookup or insert and unused kind become NOP)
  typedef enum logic [1:0] {
    OPC_NOP    = 2'd0,
    OPC_LOOKUP = 2'd1,
    OPC_INSERT = 2'd2,
    OPC_CLEAR  = 2'd3
  } op_cls_t;

  typedef struct packed {
    op_cls_t             op;
    logic [KEY_W-1:0]    key;
    logic [VAL_W-1:0]    value;
    logic [HASH_W-1:0]   hash;
  } work_item_t;

endpackage

`default_nettype wire

/* rtl/soch_front.sv */
// ---------------------------------------------------------------------------
// soch_front: input decode and work queue
// Accepts input beats, classifies the operation, folds the low 32 key bits into
// its 8-bit hash and holds up to two work items for the probe engine.
// ---------------------------------------------------------------------------
`default_nettype none

module soch_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [soch_pkg::KIND_W-1:0] in_kind,
  input  wire logic [soch_pkg::KEY_W-1:0]  in_key,
  input  wire logic [soch_pkg::VAL_W-1:0]  in_value,
  input  wire logic                        init_busy,
  output logic                             q_valid,
  output soch_pkg::work_item_t             q_item,
  input  wire logic                        q_pop
);
  import soch_pkg::*;

  localparam int QDEPTH = 2;

  work_item_t   fifo_r [QDEPTH];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   count_r, count_nxt;
  work_item_t   item;
  logic         push;
  logic         pop;
  logic         key_zero;

  // Classify the incoming beat
  always_comb begin
    key_zero   = (in_key == '0);
    item.key   = in_key;
    item.value = in_value;
    item.hash  = in_key[7:0] ^ in_key[15:8] ^ in_key[23:16] ^ in_key[31:24];
    case (in_kind)
      KIND_LOOKUP: item.op = key_zero ? OPC_NOP : OPC_LOOKUP;
      KIND_INSERT: item.op = key_zero ? OPC_NOP : OPC_INSERT;
      KIND_CLEAR:  item.op = OPC_CLEAR;
      default:     item.op = OPC_NOP;
    endcase
  end

  // Queue control
  assign in_stall = (count_r == 2'(QDEPTH)) || init_busy;
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = fifo_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= item;
    end
  end

endmodule

`default_nettype wire

/* rtl/soch_back.sv */
// ---------------------------------------------------------------------------
// soch_back: probe engine and slot memories
// Walks the slot table one slot a cycle for lookups and inserts, sweeps it
// for clears and after reset, and holds the result beat for the output.
// ---------------------------------------------------------------------------
`default_nettype none

module soch_back #(
  parameter int BUCKETS          = 256,
  parameter int SLOTS_PER_BUCKET = 2
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       q_valid,
  input  wire soch_pkg::work_item_t       q_item,
  output logic                            q_pop,
  output logic                            init_busy,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            out_hit,
  output logic [soch_pkg::VAL_W-1:0]      out_found_value,
  output logic                            out_full_res
);
  import soch_pkg::*;

  localparam int TOTAL = BUCKETS * SLOTS_PER_BUCKET;
  localparam int SW    = $clog2(TOTAL);

  typedef enum logic [4:0] {
    ST_INIT  = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_PROBE = 5'b00100,
    ST_CLEAR = 5'b01000,
    ST_RESP  = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [SW-1:0]       cur_r, cur_nxt;
  logic [SW-1:0]       cnt_r, cnt_nxt;
  op_cls_t             op_r, op_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [VAL_W-1:0]    value_r, value_nxt;
  logic                res_found_r, res_found_nxt;
  logic [VAL_W-1:0]    res_val_r, res_val_nxt;
  logic                res_full_r, res_full_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_hit_r, out_hit_nxt;
  logic [VAL_W-1:0]    out_val_r, out_val_nxt;
  logic                out_full_r, out_full_nxt;

  logic [KEY_W-1:0]    key_mem [TOTAL];
  logic [VAL_W-1:0]    val_mem [TOTAL];
  logic [KEY_W-1:0]    key_q;
  logic [VAL_W-1:0]    val_q;
  logic [SW-1:0]       rd_addr;
  logic                kwe;
  logic [KEY_W-1:0]    kwd;
  logic                vwe;

  logic [SW-1:0]       home_tab [HASH_N];
  logic [SW-1:0]       next_cur;
  logic                cur_last;
  logic                cnt_last;

  // Home slot of every hash value, fixed at elaboration
  for (genvar g = 0; g < HASH_N; g++) begin : g_home
    assign home_tab[g] = SW'(SLOTS_PER_BUCKET * (g % BUCKETS));
  end

  assign cur_last  = (cur_r == SW'(TOTAL - 1));
  assign cnt_last  = (cnt_r == SW'(TOTAL - 1));
  assign next_cur  = cur_last ? '0 : cur_r + 1'b1;
  assign init_busy = (state_r == ST_INIT);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    cnt_nxt       = cnt_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    value_nxt     = value_r;
    res_found_nxt = res_found_r;
    res_val_nxt   = res_val_r;
    res_full_nxt  = res_full_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_hit_nxt   = out_hit_r;
    out_val_nxt   = out_val_r;
    out_full_nxt  = out_full_r;
    q_pop         = 1'b0;
    kwe           = 1'b0;
    kwd           = '0;
    vwe           = 1'b0;
    rd_addr       = next_cur;

    case (state_r)
      // Sweep after reset: zero every key
      ST_INIT: begin
        kwe     = 1'b1;
        cur_nxt = next_cur;
        if (cur_last) begin
          state_nxt = ST_IDLE;
        end
      end

      // Take the next work item and start its read
      ST_IDLE: begin
        rd_addr = home_tab[q_item.hash];
        if (q_valid) begin
          q_pop         = 1'b1;
          op_nxt        = q_item.op;
          key_nxt       = q_item.key;
          value_nxt     = q_item.value;
          cnt_nxt       = '0;
          res_found_nxt = 1'b0;
          res_val_nxt   = '0;
          res_full_nxt  = 1'b0;
          case (q_item.op)
            OPC_LOOKUP, OPC_INSERT: begin
              cur_nxt   = home_tab[q_item.hash];
              state_nxt = ST_PROBE;
            end
            OPC_CLEAR: begin
              cur_nxt   = '0;
              state_nxt = ST_CLEAR;
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end
      end

      // key_q/val_q hold slot cur_r; next slot is being read
      ST_PROBE: begin
        cur_nxt = next_cur;
        cnt_nxt = cnt_r + 1'b1;
        if (op_r == OPC_LOOKUP && key_q == key_r) begin
          res_found_nxt = 1'b1;
          res_val_nxt   = val_q;
          state_nxt     = ST_RESP;
        end else if (op_r == OPC_INSERT && key_q == '0) begin
          kwe       = 1'b1;
          kwd       = key_r;
          vwe       = 1'b1;
          state_nxt = ST_RESP;
        end else if (cnt_last) begin
          res_full_nxt = (op_r == OPC_INSERT);
          state_nxt    = ST_RESP;
        end
      end

      // Clear: one slot a cycle
      ST_CLEAR: begin
        kwe     = 1'b1;
        cur_nxt = next_cur;
        if (cur_last) begin
          state_nxt = ST_RESP;
        end
      end

      // Hand the result to the output register once it is free
      ST_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = res_found_r;
          out_val_nxt   = res_val_r;
          out_full_nxt  = res_full_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    op_r        <= op_nxt;
    key_r       <= key_nxt;
    value_r     <= value_nxt;
    res_found_r <= res_found_nxt;
    res_val_r   <= res_val_nxt;
    res_full_r  <= res_full_nxt;
    out_hit_r   <= out_hit_nxt;
    out_val_r   <= out_val_nxt;
    out_full_r  <= out_full_nxt;
  end

  // Slot memories: one write port at cur_r, registered read
  always_ff @(posedge clk) begin
    if (kwe) begin
      key_mem[cur_r] <= kwd;
    end
    if (vwe) begin
      val_mem[cur_r] <= value_r;
    end
    key_q <= key_mem[rd_addr];
    val_q <= val_mem[rd_addr];
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_found_value = out_val_r;
  assign out_full_res    = out_full_r;

endmodule

`default_nettype wire

/* rtl/socket_owner_hash_cache_unit.sv */
// A lookup or insert shows its result after probing N slots, one slot a cycle, N from
//   1 to BUCKETS*SLOTS_PER_BUCKET; a clear sweeps all BUCKETS*SLOTS_PER_BUCKET slots.
// The probe engine takes the next item only after handing on the last result.
// A two-entry queue accepts items while the probe engine or output is busy.
// Reset: synchronous, active low; afterwards a sweep zeroes the key memory, with input
//   stalled until it ends.
// ---------------------------------------------------------------------------
// socket_owner_hash_cache_unit: socket inode to owner pid cache
// Open-addressing table with linear probing; front end decodes and queues,
// back end probes, inserts and clears.
// ---------------------------------------------------------------------------
`default_nettype none

module socket_owner_hash_cache_unit #(
  parameter int BUCKETS          = 256,
  parameter int SLOTS_PER_BUCKET = 2
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [soch_pkg::KIND_W-1:0] in_kind,
  input  wire logic [soch_pkg::KEY_W-1:0]  in_key,
  input  wire logic [soch_pkg::VAL_W-1:0]  in_value,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_hit,
  output logic [soch_pkg::VAL_W-1:0]       out_found_value,
  output logic                             out_full_res
);
  import soch_pkg::*;

  work_item_t q_item;
  logic       q_valid;
  logic       q_pop;
  logic       init_busy;

  // Decode and queue
  soch_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_kind   (in_kind),
    .in_key    (in_key),
    .in_value  (in_value),
    .init_busy (init_busy),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  // Probe engine
  soch_back #(
    .BUCKETS          (BUCKETS),
    .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .init_busy       (init_busy),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hit         (out_hit),
    .out_found_value (out_found_value),
    .out_full_res    (out_full_res)
  );

endmodule

`default_nettype wire
